// File: rtl/bme_pkg.sv
// Shared types and constants for the 3x3 edge-aware box mean block.
// No dependencies.
package bme_pkg;

  localparam int POS_W  = 12;  // row / column position, covers sizes up to 4096
  localparam int SIZE_W = 13;  // image size, 1 .. 4096
  localparam int SUM_W  = 12;  // nine 8-bit pixels
  localparam int CNT_W  = 4;   // neighbour count, 1 .. 9
  localparam int CFG_W  = 9;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // one centre to be computed
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [1:0]       slot;  // line slot of the centre row (row mod 3)
    logic             last;
    logic             done;
  } job_t;

  typedef struct packed {
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } size_t;

  typedef struct packed {
    logic queue_busy;
    logic back_busy;
  } hold_t;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [CFG_W-1:0] v, int maxv);
    int t;
    t = int'(v);
    if (t < 1) t = 1;
    if (t > maxv) t = maxv;
    return SIZE_W'(t);
  endfunction

  function automatic logic [1:0] slot_dec(logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [1:0] slot_inc(logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

endpackage

// File: rtl/bme_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: rtl/bme_front.sv
// Front end: takes pixels, writes the line store, lists the centres each pixel completes.
// Depends on bme_pkg.
module bme_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int AW         = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_pixel_value,
  input  logic                        cfg_wr_en,
  input  logic [bme_pkg::IDX_W-1:0]   cfg_index,
  input  logic [bme_pkg::CFG_W-1:0]   cfg_wdata,
  input  bme_pkg::hold_t              hold,
  output bme_pkg::size_t              size,
  output logic                        push,
  output bme_pkg::job_t               push_job,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [7:0]                  ram_wdata
);
  import bme_pkg::*;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_GEN  = 1'b1;

  logic              state_r, state_nxt;
  logic [SIZE_W-1:0] w_r, w_nxt, h_r, h_nxt;
  logic [POS_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic [1:0]        slot_r, slot_nxt;
  logic [POS_W-1:0]  crow_r, crow_nxt, ccol_r, ccol_nxt;
  logic [1:0]        cslot_r, cslot_nxt;
  logic [3:0]        mask_r, mask_nxt;
  logic [1:0]        combo_r, combo_nxt;
  logic              accept;
  logic              row_end, col_end;
  logic [3:0]        later;

  assign in_stall = (state_r != F_IDLE) || hold.queue_busy || hold.back_busy;
  assign accept   = in_valid && !in_stall;
  assign size.w   = w_r;
  assign size.h   = h_r;

  assign col_end = ({1'b0, col_r} + 1'b1) >= w_r;
  assign row_end = ({1'b0, row_r} + 1'b1) >= h_r;

  assign ram_we    = accept;
  assign ram_wdata = in_pixel_value;
  always_comb begin
    unique case (slot_r)
      2'd0:    ram_waddr = AW'(col_r);
      2'd1:    ram_waddr = AW'(MAX_WIDTH) + AW'(col_r);
      default: ram_waddr = AW'(2 * MAX_WIDTH) + AW'(col_r);
    endcase
  end

  // combos in output order: (r-1,c-1) (r-1,c) (r,c-1) (r,c)
  always_comb begin
    case (combo_r)
      2'd0:    later = {mask_r[3:1], 1'b0};
      2'd1:    later = {mask_r[3:2], 2'b0};
      2'd2:    later = {mask_r[3], 3'b0};
      default: later = 4'b0;
    endcase
  end

  always_comb begin
    push              = (state_r == F_GEN) && mask_r[combo_r];
    push_job.row      = combo_r[1] ? crow_r : crow_r - 1'b1;
    push_job.col      = combo_r[0] ? ccol_r : ccol_r - 1'b1;
    push_job.slot     = combo_r[1] ? cslot_r : slot_dec(cslot_r);
    push_job.last     = (later == 4'b0);
    push_job.done     = combo_r[1] && combo_r[0] && mask_r[3];
  end

  always_comb begin
    state_nxt = state_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    slot_nxt  = slot_r;
    crow_nxt  = crow_r;
    ccol_nxt  = ccol_r;
    cslot_nxt = cslot_r;
    mask_nxt  = mask_r;
    combo_nxt = combo_r;
    if (state_r == F_GEN) begin
      combo_nxt = combo_r + 1'b1;
      if (combo_r == 2'd3) state_nxt = F_IDLE;
    end
    if (accept) begin
      crow_nxt  = row_r;
      ccol_nxt  = col_r;
      cslot_nxt = slot_r;
      mask_nxt  = {row_end && col_end, row_end && (col_r != '0),
                   (row_r != '0) && col_end, (row_r != '0) && (col_r != '0)};
      combo_nxt = 2'd0;
      if (mask_nxt != 4'b0) state_nxt = F_GEN;
      if (col_end) begin
        col_nxt = '0;
        if (row_end) begin
          row_nxt  = '0;
          slot_nxt = 2'd0;
        end else begin
          row_nxt  = row_r + 1'b1;
          slot_nxt = slot_inc(slot_r);
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (cfg_wr_en && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT)) begin
      if (cfg_index == CFG_IMAGE_WIDTH) w_nxt = clamp_size(cfg_wdata, MAX_WIDTH);
      else h_nxt = clamp_size(cfg_wdata, MAX_HEIGHT);
      row_nxt  = '0;
      col_nxt  = '0;
      slot_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      w_r     <= clamp_size(CFG_W'(256), MAX_WIDTH);
      h_r     <= clamp_size(CFG_W'(256), MAX_HEIGHT);
      row_r   <= '0;
      col_r   <= '0;
      slot_r  <= 2'd0;
      combo_r <= 2'd0;
      mask_r  <= 4'b0;
    end else begin
      state_r <= state_nxt;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      slot_r  <= slot_nxt;
      combo_r <= combo_nxt;
      mask_r  <= mask_nxt;
    end
    crow_r  <= crow_nxt;
    ccol_r  <= ccol_nxt;
    cslot_r <= cslot_nxt;
  end

endmodule

// File: rtl/bme_fifo.sv
// Four-entry queue of centre requests between front and back end.
// Depends on bme_pkg.
module bme_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bme_pkg::job_t push_job,
  input  logic          pop,
  output logic          empty,
  output bme_pkg::job_t head
);
  import bme_pkg::*;

  job_t       ent_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign empty = (cnt_r == 3'd0);
  assign head  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
    if (push) ent_r[wp_r] <= push_job;
  end

endmodule

// File: rtl/bme_back.sv
// Back end: reads the 3x3 window, divides by the neighbour count, holds the result.
// Depends on bme_pkg.
module bme_back #(
  parameter int MAX_WIDTH = 256,
  parameter int AW        = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  output logic           pop,
  input  bme_pkg::job_t  job,
  input  bme_pkg::size_t size,
  output logic           busy,
  output logic           ram_re,
  output logic [AW-1:0]  ram_raddr,
  input  logic [7:0]     ram_rdata,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_mean_value,
  output logic [7:0]     out_centre_row,
  output logic [7:0]     out_centre_col,
  output logic           out_last_of_run,
  output logic           out_frame_done
);
  import bme_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_DIV  = 2'd2;
  localparam logic [1:0] B_OUT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  job_t             job_r, job_nxt;
  logic [1:0]       dr_r, dr_nxt, dc_r, dc_nxt;
  logic             issue_r, issue_nxt, pend_r, pend_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [3:0]       step_r, step_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       mean_r, mean_nxt;
  logic             row_ok, col_ok;
  logic [1:0]       nslot;
  logic [POS_W-1:0] ncol;
  logic [CNT_W:0]   trial;

  assign busy      = (state_r != B_IDLE);
  assign pop       = (state_r == B_IDLE) && !q_empty;
  assign out_valid = ov_r;
  assign out_mean_value  = mean_r;
  assign out_centre_row  = job_r.row[7:0];
  assign out_centre_col  = job_r.col[7:0];
  assign out_last_of_run = job_r.last;
  assign out_frame_done  = job_r.done;

  always_comb begin
    case (dr_r)
      2'd0:    row_ok = (job_r.row != '0);
      2'd2:    row_ok = ({1'b0, job_r.row} + 1'b1) < size.h;
      default: row_ok = 1'b1;
    endcase
    case (dc_r)
      2'd0:    col_ok = (job_r.col != '0);
      2'd2:    col_ok = ({1'b0, job_r.col} + 1'b1) < size.w;
      default: col_ok = 1'b1;
    endcase
    case (dr_r)
      2'd0:    nslot = slot_dec(job_r.slot);
      2'd2:    nslot = slot_inc(job_r.slot);
      default: nslot = job_r.slot;
    endcase
    ncol = job_r.col + POS_W'(dc_r) - 1'b1;
    case (nslot)
      2'd0:    ram_raddr = AW'(ncol);
      2'd1:    ram_raddr = AW'(MAX_WIDTH) + AW'(ncol);
      default: ram_raddr = AW'(2 * MAX_WIDTH) + AW'(ncol);
    endcase
  end

  assign ram_re = (state_r == B_READ) && issue_r && row_ok && col_ok;
  // restoring division, one quotient bit per cycle; sum_r shifts into the quotient
  assign trial  = {rem_r, sum_r[SUM_W-1]};

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    dr_nxt    = dr_r;
    dc_nxt    = dc_r;
    issue_nxt = issue_r;
    pend_nxt  = 1'b0;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    ov_nxt    = ov_r;
    mean_nxt  = mean_r;
    unique case (state_r)
      B_IDLE: begin
        if (pop) begin
          job_nxt   = job;
          dr_nxt    = 2'd0;
          dc_nxt    = 2'd0;
          issue_nxt = 1'b1;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = B_READ;
        end
      end
      B_READ: begin
        if (pend_r) begin
          sum_nxt = sum_r + SUM_W'(ram_rdata);
          cnt_nxt = cnt_r + 1'b1;
        end
        if (issue_r) begin
          pend_nxt = ram_re;
          if (dc_r == 2'd2) begin
            dc_nxt = 2'd0;
            dr_nxt = dr_r + 1'b1;
            if (dr_r == 2'd2) issue_nxt = 1'b0;
          end else begin
            dc_nxt = dc_r + 1'b1;
          end
        end else begin
          rem_nxt   = '0;
          step_nxt  = 4'(SUM_W - 1);
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        if (trial >= {1'b0, cnt_r}) begin
          rem_nxt = CNT_W'(trial - {1'b0, cnt_r});
          sum_nxt = {sum_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[CNT_W-1:0];
          sum_nxt = {sum_r[SUM_W-2:0], 1'b0};
        end
        step_nxt = step_r - 1'b1;
        if (step_r == 4'd0) begin
          mean_nxt  = sum_nxt[7:0];
          ov_nxt    = 1'b1;
          state_nxt = B_OUT;
        end
      end
      default: begin
        if (!out_stall) begin
          ov_nxt    = 1'b0;
          state_nxt = B_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
      issue_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
      issue_r <= issue_nxt;
    end
    job_r  <= job_nxt;
    dr_r   <= dr_nxt;
    dc_r   <= dc_nxt;
    sum_r  <= sum_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    mean_r <= mean_nxt;
  end

endmodule

// File: rtl/box_mean_3x3_edge_aware.sv
// Top level of the 3x3 edge-aware box mean filter.
// Depends on bme_pkg, bme_ram, bme_front, bme_fifo, bme_back.
//
// Pixels enter in raster order on in_valid/in_stall/in_pixel_value. For each
// pixel that completes one or more centres, results leave on the out_ channel
// (valid/stall) in ascending row then column order, up to four per pixel;
// out_last_of_run marks the final result of a pixel, out_frame_done the
// result of the last pixel of the map.
// cfg_wr_en with cfg_index / cfg_wdata sets image width or height and restarts
// the map at row 0, column 0.
// Flow: a pixel is accepted, then the front end steps through its four
// candidate centres and queues those it completes. Each centre leaves the
// queue, then the back end steps through the nine window positions, reading
// those inside the map through the single line-store read port, runs the
// bit-serial divide and places the result in the output register, where
// out_stall can hold it. The next pixel is accepted once all results of
// the previous one are delivered.
// Reset clears counters, queue and output valid, and sets both sizes to 256;
// the line store needs no clearing. While out_stall is high and a result is
// pending, the result holds and in_stall stays high.
module box_mean_3x3_edge_aware #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_pixel_value,
  input  logic                      cfg_wr_en,
  input  logic [bme_pkg::IDX_W-1:0] cfg_index,
  input  logic [bme_pkg::CFG_W-1:0] cfg_wdata,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_mean_value,
  output logic [7:0]                out_centre_row,
  output logic [7:0]                out_centre_col,
  output logic                      out_last_of_run,
  output logic                      out_frame_done
);
  import bme_pkg::*;

  localparam int DEPTH = 3 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  hold_t         hold;
  size_t         size;
  logic          push, pop, q_empty, back_busy;
  job_t          push_job, head;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign hold.queue_busy = !q_empty;
  assign hold.back_busy  = back_busy;

  bme_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .AW(AW)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_pixel_value,
    .cfg_wr_en, .cfg_index, .cfg_wdata,
    .hold, .size, .push, .push_job,
    .ram_we, .ram_waddr, .ram_wdata
  );

  bme_fifo u_fifo (
    .clk, .rst_n, .push, .push_job, .pop, .empty(q_empty), .head
  );

  bme_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_lines (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  bme_back #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_back (
    .clk, .rst_n, .q_empty, .pop, .job(head), .size, .busy(back_busy),
    .ram_re, .ram_raddr, .ram_rdata,
    .out_valid, .out_stall, .out_mean_value, .out_centre_row, .out_centre_col,
    .out_last_of_run, .out_frame_done
  );

endmodule

// File: rtl/bme_checker.sv
// Port-level checks for box_mean_3x3_edge_aware, bound to the top level.
// Depends only on the top level's ports.
module bme_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [7:0]                out_mean_value,
  input logic                      out_last_of_run,
  input logic                      out_frame_done
);

  a_reset_clears: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mean_value))
    else $error("stalled result changed");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_last_of_run)
    else $error("frame end not last of run");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("pixel taken while result pending");

endmodule

bind box_mean_3x3_edge_aware bme_checker u_bme_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_mean_value(out_mean_value),
  .out_last_of_run(out_last_of_run), .out_frame_done(out_frame_done)
);

// File: verif/box_mean_3x3_edge_aware_tb.sv
// Self-checking bench for box_mean_3x3_edge_aware: random and directed maps,
// a scoreboard of predicted box means, random idling on both channels.
// Depends on bme_pkg and the box_mean_3x3_edge_aware RTL.
module box_mean_3x3_edge_aware_tb;
  import bme_pkg::*;

  localparam int MAXW = 256;
  localparam int MAXH = 256;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] mean;
    logic [7:0] row;
    logic [7:0] col;
    logic       last;
    logic       done;
  } mean_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_pixel_value = 8'd0;
  logic cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_mean_value, out_centre_row, out_centre_col;
  logic out_last_of_run, out_frame_done;

  box_mean_3x3_edge_aware DUT (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [7:0] pix_rows [3][MAXW];
  int cur_row, cur_col, map_w, map_h;
  mean_rec_t mean_q [$];
  logic [7:0] pixel_q [$];
  int err_count = 0;
  int idle_pct = 10;
  bit hold_send = 1'b0;
  int idle_cycles = 0;

  function automatic void enq_pixel(logic [7:0] p);
    pixel_q.insert(pixel_q.size(), p);
  endfunction

  function automatic int clamp_dim(int v, int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [7:0] window_mean(int r, int c);
    int sum, cnt;
    sum = 0;
    cnt = 0;
    for (int i = (r > 0 ? r - 1 : 0); i <= (r + 1 < map_h ? r + 1 : map_h - 1); i++)
      for (int j = (c > 0 ? c - 1 : 0); j <= (c + 1 < map_w ? c + 1 : map_w - 1); j++) begin
        sum += pix_rows[i % 3][j];
        cnt++;
      end
    return 8'(sum / cnt);
  endfunction

  task automatic predict_pixel(logic [7:0] p);
    int rows[2], cols[2];
    int nr, nc;
    mean_rec_t m;
    nr = 0;
    nc = 0;
    pix_rows[cur_row % 3][cur_col] = p;
    if (cur_row >= 1) begin
      rows[nr] = cur_row - 1;
      nr++;
    end
    if (cur_row == map_h - 1) begin
      rows[nr] = cur_row;
      nr++;
    end
    if (cur_col >= 1) begin
      cols[nc] = cur_col - 1;
      nc++;
    end
    if (cur_col == map_w - 1) begin
      cols[nc] = cur_col;
      nc++;
    end
    for (int i = 0; i < nr; i++)
      for (int j = 0; j < nc; j++) begin
        m.mean = window_mean(rows[i], cols[j]);
        m.row = 8'(rows[i]);
        m.col = 8'(cols[j]);
        m.last = (i == nr - 1) && (j == nc - 1);
        m.done = (rows[i] == map_h - 1) && (cols[j] == map_w - 1);
        mean_q.insert(mean_q.size(), m);
      end
    if (cur_col + 1 >= map_w) begin
      cur_col = 0;
      cur_row = (cur_row + 1 >= map_h) ? 0 : cur_row + 1;
    end else begin
      cur_col++;
    end
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_pixel(in_pixel_value);
        void'(pixel_q.pop_front());
      end
      // the head of pixel_q is always the next request to send
      if ((!in_valid || !in_stall) ) begin
        if (pixel_q.size() != 0 && !hold_send && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_pixel_value <= pixel_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    mean_rec_t exp_m;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (mean_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result row %0d col %0d",
                                    out_centre_row, out_centre_col));
        end else begin
          exp_m = mean_q.pop_front();
          if (out_mean_value !== exp_m.mean)
            report_mismatch($sformatf("mean %0d, want %0d (r%0d c%0d)",
                                      out_mean_value, exp_m.mean, exp_m.row, exp_m.col));
          if (out_centre_row !== exp_m.row)
            report_mismatch($sformatf("row %0d, want %0d", out_centre_row, exp_m.row));
          if (out_centre_col !== exp_m.col)
            report_mismatch($sformatf("col %0d, want %0d", out_centre_col, exp_m.col));
          if (out_last_of_run !== exp_m.last)
            report_mismatch($sformatf("last_of_run %0b, want %0b r%0d c%0d",
                                      out_last_of_run, exp_m.last, exp_m.row, exp_m.col));
          if (out_frame_done !== exp_m.done)
            report_mismatch($sformatf("frame_done %0b, want %0b r%0d c%0d",
                                      out_frame_done, exp_m.done, exp_m.row, exp_m.col));
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_valid || mean_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_size(logic [IDX_W-1:0] idx, int v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) map_w = clamp_dim(v, MAXW);
    else map_h = clamp_dim(v, MAXH);
    cur_row = 0;
    cur_col = 0;
  endtask

  // one full map; mode picks the value pattern (random, all 0xFF or alternating 0x00/0xFF)
  task automatic queue_map(int mode);
    for (int k = 0; k < map_w * map_h; k++)
      case (mode)
        0: enq_pixel(8'($urandom));
        1: enq_pixel(8'hFF);
        default: enq_pixel((k % 2) ? 8'hFF : 8'h00);
      endcase
  endtask

  initial begin
    map_w = 256;
    map_h = 256;
    cur_row = 0;
    cur_col = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // directed: degenerate and extreme-valued maps
    write_size(CFG_IMAGE_WIDTH, 0);
    write_size(CFG_IMAGE_HEIGHT, 0);
    enq_pixel(8'h00);
    enq_pixel(8'hFF);
    wait_drained();
    write_size(CFG_IMAGE_WIDTH, 3);
    write_size(CFG_IMAGE_HEIGHT, 3);
    queue_map(1);
    queue_map(2);
    wait_drained();
    write_size(CFG_IMAGE_WIDTH, 1);
    write_size(CFG_IMAGE_HEIGHT, 4);
    queue_map(0);
    wait_drained();
    // restart mid-map
    write_size(CFG_IMAGE_WIDTH, 4);
    write_size(CFG_IMAGE_HEIGHT, 1);
    enq_pixel(8'h80);
    enq_pixel(8'h7F);
    wait_drained();
    // width above max clamps to 256: a few pixels of a single-row map
    write_size(CFG_IMAGE_WIDTH, 511);
    write_size(CFG_IMAGE_HEIGHT, 1);
    for (int k = 0; k < 6; k++) enq_pixel(8'($urandom));
    wait_drained();
    write_size(CFG_IMAGE_HEIGHT, 511);
    write_size(CFG_IMAGE_WIDTH, 1);
    for (int k = 0; k < 12; k++) enq_pixel(8'($urandom));
    wait_drained();
    // random small maps, first with no idling
    idle_pct = 0;
    for (int m = 0; m < 8; m++) begin
      if (m == 3) idle_pct = 10;
      write_size(CFG_IMAGE_WIDTH, $urandom_range(1, 5));
      write_size(CFG_IMAGE_HEIGHT, $urandom_range(1, 5));
      queue_map(0);
      if (m == 5) begin
        while (pixel_q.size() > 3) @(posedge clk);
        hold_send = 1'b1;
        while (in_valid || mean_q.size() != 0) @(posedge clk);
        hold_send = 1'b0;
      end
      wait_drained();
    end
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
